[hdl/sct_pkg.sv]
// Shared types and constants for the shell command tokenizer.
// Holds the byte codes, event kinds, lexer modes and the command record
// passed from the front classifier through the queue to the back end.
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  // Default number of command entries between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Bytes with a meaning to the lexer.
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Event kinds on the result channel.
  typedef enum logic [1:0] {
    K_CHAR = 2'd0,
    K_END  = 2'd1,
    K_LINE = 2'd2,
    K_ERR  = 2'd3
  } kind_t;

  // Lexer modes, one-hot.
  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_WORD  = 4'b0010,
    MODE_QUOTE = 4'b0100,
    MODE_GT    = 4'b1000
  } lex_mode_t;

  // One classified input byte: up to three events in order.
  typedef struct packed {
    logic [1:0] cnt;
    kind_t      k0;
    kind_t      k1;
    kind_t      k2;
    logic [7:0] tbyte;
  } cmd_t;

endpackage

`default_nettype wire

[hdl/sct_front.sv]
// Front end of the shell command tokenizer: accepts input bytes, tracks
// the lexer mode and turns each byte into an event command for the queue.
// Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic [7:0]   in_ch,
  output logic              in_stall,
  input  wire logic         q_full,
  output logic              push,
  output sct_pkg::cmd_t     push_cmd
);
  import sct_pkg::*;

  lex_mode_t mode_r;
  lex_mode_t mode_nxt;
  cmd_t      cmd;
  logic      acc;
  logic      is_sep;
  logic      is_single;

  // The front only waits when the queue has no room.
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  // Byte classes.
  always_comb begin
    is_sep    = in_ch inside {CH_SP, CH_TAB};
    is_single = in_ch inside {CH_SEMI, CH_LT, CH_PIPE};
  end

  // Classification: build the event list and the next mode.
  always_comb begin
    cmd       = '0;
    cmd.tbyte = in_ch;
    mode_nxt  = mode_r;
    case (mode_r)
      MODE_IDLE: begin
        if (is_sep) begin
          mode_nxt = MODE_IDLE;
        end else if (in_ch == CH_QUOTE) begin
          mode_nxt = MODE_QUOTE;
        end else if (is_single) begin
          cmd.cnt = 2'd2; cmd.k0 = K_CHAR; cmd.k1 = K_END;
        end else if (in_ch == CH_GT) begin
          cmd.cnt = 2'd1; cmd.k0 = K_CHAR;
          mode_nxt = MODE_GT;
        end else if (in_ch == CH_NL) begin
          cmd.cnt = 2'd1; cmd.k0 = K_LINE;
        end else begin
          cmd.cnt = 2'd1; cmd.k0 = K_CHAR;
          mode_nxt = MODE_WORD;
        end
      end
      MODE_WORD: begin
        if (is_sep) begin
          cmd.cnt = 2'd1; cmd.k0 = K_END;
          mode_nxt = MODE_IDLE;
        end else if (in_ch == CH_NL) begin
          cmd.cnt = 2'd2; cmd.k0 = K_END; cmd.k1 = K_LINE;
          mode_nxt = MODE_IDLE;
        end else if (is_single) begin
          cmd.cnt = 2'd3; cmd.k0 = K_END; cmd.k1 = K_CHAR; cmd.k2 = K_END;
          mode_nxt = MODE_IDLE;
        end else if (in_ch == CH_GT) begin
          cmd.cnt = 2'd2; cmd.k0 = K_END; cmd.k1 = K_CHAR;
          mode_nxt = MODE_GT;
        end else begin
          cmd.cnt = 2'd1; cmd.k0 = K_CHAR;
        end
      end
      MODE_QUOTE: begin
        if (in_ch == CH_QUOTE) begin
          cmd.cnt = 2'd1; cmd.k0 = K_END;
          mode_nxt = MODE_IDLE;
        end else if (in_ch == CH_NL) begin
          cmd.cnt = 2'd1; cmd.k0 = K_ERR;
          mode_nxt = MODE_IDLE;
        end else begin
          cmd.cnt = 2'd1; cmd.k0 = K_CHAR;
        end
      end
      MODE_GT: begin
        if (is_single) begin
          cmd.cnt = 2'd3; cmd.k0 = K_END; cmd.k1 = K_CHAR; cmd.k2 = K_END;
          mode_nxt = MODE_IDLE;
        end else if (in_ch == CH_GT) begin
          cmd.cnt = 2'd2; cmd.k0 = K_CHAR; cmd.k1 = K_END;
          mode_nxt = MODE_IDLE;
        end else if (is_sep) begin
          cmd.cnt = 2'd1; cmd.k0 = K_END;
          mode_nxt = MODE_IDLE;
        end else if (in_ch == CH_NL) begin
          cmd.cnt = 2'd2; cmd.k0 = K_END; cmd.k1 = K_LINE;
          mode_nxt = MODE_IDLE;
        end else begin
          cmd.cnt = 2'd2; cmd.k0 = K_END; cmd.k1 = K_CHAR;
          mode_nxt = MODE_WORD;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  // Only bytes that produce events go into the queue.
  assign push     = acc && (cmd.cnt != 2'd0);
  assign push_cmd = cmd;

  // Mode register advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
    end else if (acc) begin
      mode_r <= mode_nxt;
    end
  end

  // A newline always returns the lexer to the idle mode.
  a_nl_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_ch == CH_NL) |=> mode_r == MODE_IDLE)
    else $error("newline did not return lexer to idle");

  // Inside quotes, an ordinary byte is passed on as a single character.
  a_quote_char: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (mode_r == MODE_QUOTE) && (in_ch != CH_QUOTE) && (in_ch != CH_NL)
    |-> push && (push_cmd.cnt == 2'd1) && (push_cmd.k0 == K_CHAR))
    else $error("quoted byte not forwarded as one character");

  // A separator between tokens produces nothing.
  a_idle_sep: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (mode_r == MODE_IDLE) && ((in_ch == CH_SP) || (in_ch == CH_TAB))
    |-> !push)
    else $error("separator in idle mode produced events");

endmodule

`default_nettype wire

[hdl/sct_queue.sv]
// Command queue of the shell command tokenizer, decoupling the front
// classifier from the back-end event sequencer. Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_queue #(
  parameter int unsigned QDEPTH = sct_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sct_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output sct_pkg::cmd_t      head_cmd,
  output logic               q_valid,
  output logic               q_full
);
  import sct_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QDEPTH);

  cmd_t          entry_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign q_valid  = (count_r != '0);
  assign q_full   = (count_r == CNT_FULL);
  assign head_cmd = entry_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage; no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != CNT_FULL)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from an empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue occupancy did not grow on push");

endmodule

`default_nettype wire

[hdl/sct_back.sv]
// Back end of the shell command tokenizer: takes commands from the queue
// and plays out their events one per beat into the output register while
// the output is not stalled. Depends on sct_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sct_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire sct_pkg::cmd_t head_cmd,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_token_byte,
  output logic               out_last
);
  import sct_pkg::*;

  cmd_t       cmd_r;
  logic       cmd_valid_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  kind_t      out_kind_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic  out_free;
  logic  emit;
  logic  cmd_last;
  logic  cmd_take;
  kind_t sel_kind;

  // Output register can load when empty or when its beat is taken.
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = cmd_valid_r && out_free;
  assign cmd_last = (idx_r == (cmd_r.cnt - 2'd1));
  assign cmd_take = !cmd_valid_r || (emit && cmd_last);
  assign pop      = cmd_take && q_valid;

  // Pick the event at the current position of the command.
  always_comb begin
    case (idx_r)
      2'd0:    sel_kind = cmd_r.k0;
      2'd1:    sel_kind = cmd_r.k1;
      default: sel_kind = cmd_r.k2;
    endcase
  end

  // Command register and position within it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (pop) begin
      cmd_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (cmd_take) begin
      cmd_valid_r <= 1'b0;
    end else if (emit) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head_cmd;
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload; the byte is zero for every kind but a character.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= sel_kind;
      out_byte_r <= (sel_kind == K_CHAR) ? cmd_r.tbyte : 8'd0;
      out_last_r <= cmd_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_token_byte = out_byte_r;
  assign out_last       = out_last_r;

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    emit && cmd_last |=> out_valid_r && out_last_r)
    else $error("final event of a byte not flagged last");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid_r |-> (cmd_r.cnt != 2'd0) && (idx_r < cmd_r.cnt))
    else $error("event position beyond command length");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r != K_CHAR) |-> out_byte_r == 8'd0)
    else $error("non-character event carries a byte");

endmodule

`default_nettype wire

[hdl/shell_command_tokenizer.sv]
// Top level of the shell command tokenizer: front classifier, command
// queue and back-end event sequencer. Depends on sct_pkg.
//
// Usage: one command-line byte per beat enters on in_valid / in_ch,
// held while in_stall is high. Token events leave on out_valid with
// out_kind (char, token end, line end, unclosed-quote error), out_token_byte
// and out_last, which marks the final event caused by one input byte. The
// consumer holds out_stall high to pause the output; the event waits in
// the output register.
// Path: a byte's command waits in a queue entry, then in the sequencer's
// command register, before its first event loads the output register.
// Throughput: one input byte per cycle while each byte gives at most one
// event and out_stall stays low; the output port delivers one event per
// cycle unless stalled, so a byte that yields two or three events holds
// the output for each in turn. The command queue (QUEUE_DEPTH entries)
// absorbs these bursts; in_stall rises only when it is full. A separator
// outside quotes that ends no token gives no event and skips the queue.
// Reset (synchronous, rst_n low) returns the lexer to idle between tokens
// and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module shell_command_tokenizer #(
  parameter int unsigned QUEUE_DEPTH = sct_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_ch,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_token_byte,
  output logic            out_last
);
  import sct_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head_cmd;
  logic q_valid;
  logic q_full;

  // Byte classification and lexer mode.
  sct_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ch    (in_ch),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue between front and back.
  sct_queue #(
    .QDEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_valid  (q_valid),
    .q_full   (q_full)
  );

  // Event sequencing and output register.
  sct_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .head_cmd       (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_token_byte (out_token_byte),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
